// File: src/two_street_traffic_light_controller_macros.svh
// assertion macros for the two-street traffic light controller
`ifndef TWO_STREET_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define TWO_STREET_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSLC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tslc check failed");

// next-cycle implication, checked out of reset
`define TSLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tslc check failed");

`endif

// File: src/tslc_pkg.sv
// types and constants shared by the traffic light controller modules
package tslc_pkg;

    localparam logic [1:0] PH_ONE    = 2'd0;
    localparam logic [1:0] PH_TWO    = 2'd1;
    localparam logic [1:0] PH_MANUAL = 2'd2;

    localparam logic [5:0] PAT_ALL_STOP  = 6'h11;
    localparam logic [5:0] PAT_ONE_AMBER = 6'h21;
    localparam logic [5:0] PAT_HANDOVER  = 6'h0A;
    localparam logic [5:0] PAT_TWO_AMBER = 6'h0C;

    // active-low digit enables
    localparam logic [1:0] EN_OFF  = 2'b11;
    localparam logic [1:0] EN_ONES = 2'b10;
    localparam logic [1:0] EN_TENS = 2'b01;

    localparam logic [1:0] CFG_ONE_GREEN = 2'd0;
    localparam logic [1:0] CFG_TWO_GREEN = 2'd1;
    localparam logic [1:0] CFG_AMBER     = 2'd2;
    localparam logic [1:0] CFG_TICKS     = 2'd3;

    localparam logic [6:0]  RST_ONE_GREEN = 7'd23;
    localparam logic [6:0]  RST_TWO_GREEN = 7'd15;
    localparam logic [3:0]  RST_AMBER     = 4'd3;
    localparam logic [15:0] RST_TICKS     = 16'd100;
    localparam logic [6:0]  GREEN_MAX     = 7'd99;
    localparam logic [3:0]  AMBER_MAX     = 4'd9;

    typedef struct packed {
        logic [6:0]  one_green;
        logic [6:0]  two_green;
        logic [3:0]  amber;
        logic [15:0] ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  countdown;
        logic [15:0] tick_count;
        logic        show_tens;
        logic [5:0]  lamps;
        logic        manual_next_phase;
        logic        manual_active;
    } state_t;

    typedef struct packed {
        logic [5:0] lamp_pattern;
        logic [3:0] digit_value;
        logic [1:0] digit_enable_n;
    } result_t;

endpackage

// File: src/two_street_traffic_light_controller.sv
// a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle while m_ready takes results; the single result register frees as it is taken
// the whole step is one pass of logic from the state register to the result register
// reset (aresetn low, synchronous): street one automatic with a count of 23,
// all-stop lamps, configuration back to 23 / 15 / 3 / 100, no result pending
module two_street_traffic_light_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_auto_switch,
    input  logic        s_button_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_lamp_pattern,
    output logic [3:0]  m_digit_value,
    output logic [1:0]  m_digit_enable_n
);

    `include "two_street_traffic_light_controller_macros.svh"

    tslc_pkg::cfg_t    cfg;
    tslc_pkg::state_t  state_reg;
    tslc_pkg::state_t  state_next;
    tslc_pkg::result_t res_next;
    tslc_pkg::result_t res_reg;
    logic              m_valid_reg;
    logic              accept;

    tslc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tslc_step u_step (
        .cfg          (cfg),
        .st           (state_reg),
        .mode         (s_mode),
        .auto_switch  (s_auto_switch),
        .button_level (s_button_level),
        .nxt          (state_next),
        .res          (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase             <= tslc_pkg::PH_ONE;
            state_reg.countdown         <= tslc_pkg::RST_ONE_GREEN;
            state_reg.tick_count        <= 16'd0;
            state_reg.show_tens         <= 1'b0;
            state_reg.lamps             <= tslc_pkg::PAT_ALL_STOP;
            state_reg.manual_next_phase <= 1'b0;
            state_reg.manual_active     <= 1'b0;
            m_valid_reg                 <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lamp_pattern   = res_reg.lamp_pattern;
    assign m_digit_value    = res_reg.digit_value;
    assign m_digit_enable_n = res_reg.digit_enable_n;

    `TSLC_ASSERT_NOW(a_manual_phase, aclk, aresetn, state_reg.manual_active, state_reg.phase == tslc_pkg::PH_MANUAL)
    `TSLC_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, state_reg.countdown <= tslc_pkg::GREEN_MAX)
    `TSLC_ASSERT_NOW(a_dark_zero, aclk, aresetn, m_valid_reg && (res_reg.digit_enable_n == tslc_pkg::EN_OFF), res_reg.digit_value == 4'd0)
    `TSLC_ASSERT_NOW(a_one_digit, aclk, aresetn, m_valid_reg, res_reg.digit_enable_n != 2'b00)
    `TSLC_ASSERT_NEXT(a_accept_shows, aclk, aresetn, accept, m_valid_reg)

endmodule

// File: src/tslc_cfg.sv
// configuration registers; green and amber times saturate on write, ticks are taken as written
module tslc_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output tslc_pkg::cfg_t    cfg
);

    tslc_pkg::cfg_t cfg_reg;
    logic [6:0] green_sat;
    logic [3:0] amber_sat;

    assign green_sat = (cfg_data[6:0] > tslc_pkg::GREEN_MAX) ? tslc_pkg::GREEN_MAX
                                                              : cfg_data[6:0];
    assign amber_sat = (cfg_data[3:0] > tslc_pkg::AMBER_MAX) ? tslc_pkg::AMBER_MAX
                                                              : cfg_data[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_green <= tslc_pkg::RST_ONE_GREEN;
            cfg_reg.two_green <= tslc_pkg::RST_TWO_GREEN;
            cfg_reg.amber     <= tslc_pkg::RST_AMBER;
            cfg_reg.ticks     <= tslc_pkg::RST_TICKS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tslc_pkg::CFG_ONE_GREEN: cfg_reg.one_green <= green_sat;
                tslc_pkg::CFG_TWO_GREEN: cfg_reg.two_green <= green_sat;
                tslc_pkg::CFG_AMBER:     cfg_reg.amber     <= amber_sat;
                tslc_pkg::CFG_TICKS:     cfg_reg.ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/tslc_step.sv
// next-state and result logic for one item
module tslc_step (
    input  tslc_pkg::cfg_t    cfg,
    input  tslc_pkg::state_t  st,
    input  logic              mode,
    input  logic              auto_switch,
    input  logic              button_level,
    output tslc_pkg::state_t  nxt,
    output tslc_pkg::result_t res
);

    logic        resume;
    logic [1:0]  eff_phase;
    logic [6:0]  eff_c;
    logic [15:0] eff_tick;
    logic        eff_show;
    logic [15:0] tick_inc;
    logic        done;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones_w;
    logic [3:0]  ones;

    // leaving manual restarts street one with a full count in the same item
    assign resume = !mode && !st.manual_active && (st.phase == tslc_pkg::PH_MANUAL)
                    && auto_switch && button_level;

    assign eff_phase = resume ? tslc_pkg::PH_ONE : st.phase;
    assign eff_c     = resume ? cfg.one_green    : st.countdown;
    assign eff_tick  = resume ? 16'd0            : st.tick_count;
    assign eff_show  = resume ? 1'b0             : st.show_tens;

    assign tick_inc = eff_tick + 16'd1;
    assign done     = (tick_inc >= cfg.ticks) || (tick_inc == 16'd0);

    // divide by ten through the reciprocal, exact for every 7-bit count (0 to 127)
    assign prod   = 15'(eff_c) * 15'd205;
    assign tens   = prod[14:11];
    assign ones_w = eff_c - 7'(tens) * 7'd10;
    assign ones   = ones_w[3:0];

    always_comb begin
        nxt                = st;
        res.lamp_pattern   = st.lamps;
        res.digit_value    = 4'd0;
        res.digit_enable_n = tslc_pkg::EN_OFF;
        if (mode) begin
            if (!auto_switch && !st.manual_active) begin
                nxt.lamps         = st.manual_next_phase ? tslc_pkg::PAT_TWO_AMBER
                                                         : tslc_pkg::PAT_ONE_AMBER;
                nxt.countdown     = 7'(cfg.amber);
                nxt.tick_count    = 16'd0;
                nxt.manual_active = 1'b1;
                nxt.phase         = tslc_pkg::PH_MANUAL;
                res.lamp_pattern  = nxt.lamps;
                res.digit_value    = cfg.amber;
                res.digit_enable_n = tslc_pkg::EN_ONES;
            end
        end else if (st.manual_active) begin
            res.digit_value    = ones;
            res.digit_enable_n = tslc_pkg::EN_ONES;
            nxt.tick_count     = done ? 16'd0 : tick_inc;
            if (done) begin
                if (st.countdown == 7'd0) begin
                    nxt.lamps             = st.manual_next_phase ? tslc_pkg::PAT_ALL_STOP
                                                                 : tslc_pkg::PAT_HANDOVER;
                    nxt.manual_next_phase = !st.manual_next_phase;
                    nxt.manual_active     = 1'b0;
                end else begin
                    nxt.countdown = st.countdown - 7'd1;
                end
            end
        end else if ((st.phase == tslc_pkg::PH_MANUAL) && !resume) begin
            // held in manual, lamps kept, digits dark
        end else if ((st.phase != tslc_pkg::PH_MANUAL) && !auto_switch && button_level) begin
            nxt.phase        = tslc_pkg::PH_MANUAL;
            nxt.lamps        = tslc_pkg::PAT_ALL_STOP;
            nxt.countdown    = cfg.one_green;
            nxt.tick_count   = 16'd0;
            nxt.show_tens    = 1'b0;
            res.lamp_pattern = tslc_pkg::PAT_ALL_STOP;
        end else begin
            nxt.phase = eff_phase;
            if (eff_phase == tslc_pkg::PH_ONE) begin
                if (eff_c == 7'd0)
                    nxt.lamps = tslc_pkg::PAT_HANDOVER;
                else if (eff_c <= 7'(cfg.amber))
                    nxt.lamps = tslc_pkg::PAT_ONE_AMBER;
                else
                    nxt.lamps = tslc_pkg::PAT_ALL_STOP;
            end else begin
                if (eff_c == 7'd0)
                    nxt.lamps = tslc_pkg::PAT_ALL_STOP;
                else if (eff_c <= 7'(cfg.amber))
                    nxt.lamps = tslc_pkg::PAT_TWO_AMBER;
                else
                    nxt.lamps = tslc_pkg::PAT_HANDOVER;
            end
            res.lamp_pattern   = nxt.lamps;
            res.digit_value    = eff_show ? tens : ones;
            res.digit_enable_n = eff_show ? tslc_pkg::EN_TENS : tslc_pkg::EN_ONES;
            nxt.show_tens      = !eff_show;
            nxt.tick_count     = done ? 16'd0 : tick_inc;
            nxt.countdown      = eff_c;
            if (done) begin
                if (eff_c == 7'd0) begin
                    if (eff_phase == tslc_pkg::PH_ONE) begin
                        nxt.phase     = tslc_pkg::PH_TWO;
                        nxt.countdown = cfg.two_green;
                    end else begin
                        nxt.phase     = tslc_pkg::PH_ONE;
                        nxt.countdown = cfg.one_green;
                    end
                end else begin
                    nxt.countdown = eff_c - 7'd1;
                end
            end
        end
    end

endmodule
